// ----- rtl/core/injection_timing_meter_and_regulator_top_defines.svh -----
// assertion macros for the injection timing meter and regulator
`ifndef INJECTION_TIMING_METER_AND_REGULATOR_TOP_DEFINES_SVH
`define INJECTION_TIMING_METER_AND_REGULATOR_TOP_DEFINES_SVH

// same-cycle implication, reset masks the check
`define ITMR_ASSERT(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, reset masks the check
`define ITMR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/itmr_pkg.sv -----
// types, codes and constants of the injection timing meter and regulator
package itmr_pkg;

	localparam int AVG_LEN_DEF = 2;

	localparam int DIV_W = 28;
	localparam int DVS_W = 16;

	localparam int SPEED_NUM     = 1250000;
	localparam int SPEED_MIN     = 100;
	localparam int ANGLE_SCALE   = 3600;
	localparam int ROUND_ADD     = 5;
	localparam int ROUND_DIV     = 10;
	localparam int FOLD_LIMIT    = 180;
	localparam int FOLD_BASE     = 360;
	localparam int DRIVE_MAX     = 2550;
	localparam int RPM_STEP      = 800;
	localparam int SET_OFFSET    = 8;
	localparam int ERR_STEP      = 10;
	localparam int ERR_LIMIT     = 20;
	localparam int ERR_REG_LIMIT = 5;
	localparam int FAULT_LIMIT   = 2;
	// floor(x * DUTY_RECIP / 2^16) equals x / 10 for x up to the drive maximum
	localparam int DUTY_RECIP    = 6554;

	// reciprocal multiply, exact for any 16-bit dividend
	localparam int RND_SHIFT = 20;
	localparam int RND_RECIP = ((1 << RND_SHIFT) + ROUND_DIV - 1) / ROUND_DIV;
	localparam int RPM_SHIFT = 26;
	localparam int RPM_RECIP = ((1 << RPM_SHIFT) + RPM_STEP - 1) / RPM_STEP;

	localparam logic [7:0]  GAIN_POS_RST = 8'd4;
	localparam logic [7:0]  GAIN_NEG_RST = 8'd1;
	localparam logic [7:0]  GAIN_INT_RST = 8'd0;
	localparam logic [15:0] SCALE_RST    = 16'd10000;

	typedef enum logic [1:0] {
		OP_INJ   = 2'd0,
		OP_CRANK = 2'd1,
		OP_OVF   = 2'd2,
		OP_TICK  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		CFG_GAIN_POS = 2'd0,
		CFG_GAIN_NEG = 2'd1,
		CFG_GAIN_INT = 2'd2,
		CFG_SCALE    = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] timer_value;
	} in_item_t;

	typedef struct packed {
		logic [15:0] angle_shown;
		logic        angle_negative;
		logic [15:0] engine_speed;
		logic [7:0]  duty;
		logic        fault;
	} out_item_t;

	typedef struct packed {
		logic             start;
		logic [DIV_W-1:0] dividend;
		logic [DVS_W-1:0] divisor;
	} div_req_t;

endpackage

// ----- rtl/core/itmr_div.sv -----
// restoring divider, one quotient bit per cycle
module itmr_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  itmr_pkg::div_req_t            req,
	output logic                          done,
	output logic [itmr_pkg::DIV_W-1:0]    quot
);
	import itmr_pkg::*;

	localparam int CW = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] dvd_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic             qbit;

	assign trial = {rem_q[DVS_W-1:0], dvd_q[DIV_W-1]};
	assign qbit  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= qbit ? (trial - {1'b0, dvs_q}) : trial;
			dvd_q <= {dvd_q[DIV_W-2:0], qbit};
		end
	end

	assign done = done_q;
	assign quot = dvd_q;

endmodule

// ----- rtl/core/injection_timing_meter_and_regulator_top.sv -----
// top level of the injection timing meter and regulator
//
//  channel | direction | handshake             | payload
//  in      | input     | in_valid / in_ready   | in_item (operation, timer_value)
//  out     | output    | out_valid / out_ready | out_item (angle, sign, speed, duty, fault)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one item at a time; injector pulse, overflow and a crank pulse with a short
// period go straight to the output, a crank pulse with a valid period waits on
// a divider pass, a control tick with a period runs a divider pass, rounding,
// averaging and multiplier steps, without one the check and multiplier steps
// the shared bit-serial divider sets the time of the items that use it
// reset clears the sequencer state and loads the register defaults; cfg is always ready
// a result waits in the output register while the next item is taken

module injection_timing_meter_and_regulator_top #(
	parameter int AVERAGE_LEN = itmr_pkg::AVG_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  itmr_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output itmr_pkg::out_item_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [15:0]         cfg_data
);
	import itmr_pkg::*;

	localparam int SCW       = $clog2(AVERAGE_LEN + 1);
	// average by reciprocal multiply
	localparam int AVG_SH    = 16 + $clog2(AVERAGE_LEN);
	localparam int AVG_RECIP = ((1 << AVG_SH) + AVERAGE_LEN - 1) / AVERAGE_LEN;

	// one-hot sequencer states
	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_SPD  = 14'b00000000000010,
		S_MD   = 14'b00000000000100,
		S_DA   = 14'b00000000001000,
		S_WA   = 14'b00000000010000,
		S_WR   = 14'b00000000100000,
		S_WV   = 14'b00000001000000,
		S_CHK  = 14'b00000010000000,
		S_WS   = 14'b00000100000000,
		S_M1   = 14'b00001000000000,
		S_M2   = 14'b00010000000000,
		S_M3   = 14'b00100000000000,
		S_DRV  = 14'b01000000000000,
		S_OUT  = 14'b10000000000000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [7:0]  gain_pos_q, gain_neg_q, gain_int_q;
	logic [15:0] scale_q;

	// measurement and regulator state
	logic [15:0]    period_q, offset_q, speed_q, sum_q, avg_q, acc_q;
	logic           started_q, ended_q, sign_q;
	logic [4:0]     err_q;
	logic [SCW-1:0] cnt_q;
	logic [11:0]    drive_q;
	logic signed [9:0]  e_q;
	logic signed [18:0] p_q;

	// shared divider
	div_req_t         div_req_q;
	logic             div_done;
	logic [DIV_W-1:0] div_quot;

	// shared multiplier, registered product
	logic signed [16:0] mul_a, mul_b;
	logic signed [33:0] mul_q;

	// output register
	out_item_t out_q;
	logic      out_valid_q;

	// angle path helpers
	logic [15:0]  rnd_q;
	logic [32:0]  rnd_prod;
	logic [32:0]  rpm_prod;
	logic [32:0]  avg_prod;
	logic [15:0]  angle;
	logic         fold;
	logic [15:0]  sum_n;
	logic         avg_full;
	logic [9:0]   setpoint;
	logic signed [27:0] drv_n;
	logic [24:0]  duty_prod;

	itmr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.done   (div_done),
		.quot   (div_quot)
	);

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// rounding to whole degrees, divide by ten via reciprocal
	assign rnd_prod = 33'(16'(div_quot[15:0] + 16'(ROUND_ADD))) * 33'(RND_RECIP);

	// fold past half turn, running sum
	assign fold     = (rnd_q > 16'(FOLD_LIMIT));
	assign angle    = fold ? 16'(16'(FOLD_BASE) - rnd_q) : rnd_q;
	assign sum_n    = sum_q + angle;
	assign avg_full = (({1'b0, cnt_q} + 1'b1) >= (SCW + 1)'(AVERAGE_LEN));
	assign avg_prod = 33'(sum_q) * 33'(AVG_RECIP);

	// setpoint from speed, divide by rpm step via reciprocal
	assign rpm_prod = 33'(speed_q) * 33'(RPM_RECIP);
	assign setpoint = 10'(rpm_prod >> RPM_SHIFT) + 10'(SET_OFFSET);

	// drive minus regulator output, formed wide then clamped
	assign drv_n = {16'b0, drive_q} - ({{9{p_q[18]}}, p_q} + mul_q[27:0]);

	// duty by reciprocal multiply
	assign duty_prod = 25'(drive_q) * 25'(DUTY_RECIP);

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_MD: begin
				mul_a = {1'b0, 16'(period_q - offset_q)};
				mul_b = 17'(ANGLE_SCALE);
			end
			S_M1: begin
				mul_a = {{7{e_q[9]}}, e_q};
				mul_b = {1'b0, scale_q};
			end
			S_M2: begin
				mul_a = {9'b0, (e_q[9] ? gain_neg_q : gain_pos_q)};
				mul_b = {{7{e_q[9]}}, e_q};
			end
			S_M3: begin
				mul_a = {9'b0, gain_int_q};
				mul_b = {acc_q[15], acc_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= mul_a * mul_b;
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_pos_q <= GAIN_POS_RST;
			gain_neg_q <= GAIN_NEG_RST;
			gain_int_q <= GAIN_INT_RST;
			scale_q    <= SCALE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_GAIN_POS: gain_pos_q <= cfg_data[7:0];
				CFG_GAIN_NEG: gain_neg_q <= cfg_data[7:0];
				CFG_GAIN_INT: gain_int_q <= cfg_data[7:0];
				CFG_SCALE:    scale_q    <= cfg_data;
				default:      scale_q    <= scale_q;
			endcase
		end
	end

	// sequencer and state updates
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			period_q    <= '0;
			offset_q    <= '0;
			started_q   <= 1'b0;
			ended_q     <= 1'b0;
			err_q       <= '0;
			speed_q     <= '0;
			sign_q      <= 1'b0;
			sum_q       <= '0;
			cnt_q       <= '0;
			avg_q       <= '0;
			acc_q       <= '0;
			drive_q     <= '0;
			rnd_q       <= '0;
			div_req_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			div_req_q.start <= 1'b0;
			if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						case (in_item.operation)
							OP_INJ: begin
								if (!started_q && ended_q) begin
									period_q <= in_item.timer_value;
									err_q    <= '0;
								end else begin
									period_q <= '0;
								end
								started_q <= 1'b1;
								ended_q   <= 1'b0;
								state_q   <= S_OUT;
							end
							OP_CRANK: begin
								if (started_q && !ended_q) begin
									offset_q  <= in_item.timer_value;
									started_q <= 1'b0;
									ended_q   <= 1'b1;
								end
								if (period_q > 16'(SPEED_MIN)) begin
									div_req_q.start    <= 1'b1;
									div_req_q.dividend <= DIV_W'(SPEED_NUM);
									div_req_q.divisor  <= period_q;
									state_q            <= S_SPD;
								end else begin
									state_q <= S_OUT;
								end
							end
							OP_OVF: begin
								if (err_q < 5'(ERR_LIMIT))
									err_q <= err_q + 5'(ERR_STEP);
								state_q <= S_OUT;
							end
							OP_TICK: begin
								if (period_q != '0) begin
									err_q   <= '0;
									state_q <= S_MD;
								end else begin
									state_q <= S_CHK;
								end
							end
							default: state_q <= S_OUT;
						endcase
					end
				end
				S_SPD: begin
					// speed = quotient * 12, low 16 bits
					if (div_done) begin
						speed_q <= 16'({div_quot[15:0], 3'b0} + {1'b0, div_quot[15:0], 2'b0});
						state_q <= S_OUT;
					end
				end
				S_MD: state_q <= S_DA;
				S_DA: begin
					div_req_q.start    <= 1'b1;
					div_req_q.dividend <= mul_q[DIV_W-1:0];
					div_req_q.divisor  <= period_q;
					state_q            <= S_WA;
				end
				S_WA: begin
					// round to whole degrees
					if (div_done) begin
						rnd_q   <= 16'(rnd_prod >> RND_SHIFT);
						state_q <= S_WR;
					end
				end
				S_WR: begin
					sign_q <= fold;
					sum_q  <= sum_n;
					if (avg_full) begin
						state_q <= S_WV;
					end else begin
						cnt_q   <= cnt_q + 1'b1;
						state_q <= S_CHK;
					end
				end
				S_WV: begin
					avg_q   <= 16'(avg_prod >> AVG_SH);
					sum_q   <= '0;
					cnt_q   <= '0;
					state_q <= S_CHK;
				end
				S_CHK: begin
					// regulator runs only with few faults and a folded angle
					if (err_q < 5'(ERR_REG_LIMIT) && sign_q)
						state_q <= S_WS;
					else
						state_q <= S_OUT;
				end
				S_WS: begin
					e_q     <= $signed(setpoint) - $signed({{2{avg_q[7]}}, avg_q[7:0]});
					state_q <= S_M1;
				end
				S_M1: state_q <= S_M2;
				S_M2: begin
					acc_q   <= acc_q + mul_q[15:0];
					state_q <= S_M3;
				end
				S_M3: begin
					p_q     <= mul_q[18:0];
					state_q <= S_DRV;
				end
				S_DRV: begin
					if (drv_n < 0)
						drive_q <= '0;
					else if (drv_n > 28'(DRIVE_MAX))
						drive_q <= 12'(DRIVE_MAX);
					else
						drive_q <= drv_n[11:0];
					state_q <= S_OUT;
				end
				S_OUT: begin
					// wait until the output register is free
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (state_q == S_OUT && (!out_valid_q || out_ready)) begin
			out_q.angle_shown    <= avg_q;
			out_q.angle_negative <= sign_q;
			out_q.engine_speed   <= speed_q;
			out_q.duty           <= duty_prod[23:16];
			out_q.fault          <= (err_q > 5'(FAULT_LIMIT));
		end
	end

endmodule

// ----- rtl/core/itmr_checker.sv -----
// port-level checks of the injection timing meter and regulator
`include "injection_timing_meter_and_regulator_top_defines.svh"

module itmr_props (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input itmr_pkg::out_item_t out_item,
	input logic                cfg_valid,
	input logic                cfg_ready
);
	import itmr_pkg::*;

	`ITMR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`ITMR_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(out_item), "stalled result changed")
	`ITMR_ASSERT_NEXT(a_busy, clk, arst_n, in_valid && in_ready, !in_ready, "item taken while busy")
	`ITMR_ASSERT(a_cfg_rdy, clk, arst_n, cfg_valid, cfg_ready, "config write refused")

endmodule

bind injection_timing_meter_and_regulator_top itmr_props u_itmr_props (.*);

// ----- dv/itmr_checker.sv -----
// checker: predicts each result of the injection timing meter and compares it
`timescale 1ns / 1ps

module itmr_checker
	import itmr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  in_item_t    in_item,
	input  logic        out_valid,
	input  logic        out_ready,
	input  out_item_t   out_item,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);

	logic [7:0]  kp_pos, kp_neg, ki;
	logic [15:0] iscale;
	logic [15:0] period, offset, speed, asum, aavg, integ, drive;
	logic        started, ended, sgn;
	logic [4:0]  errs;
	int          nsamp;
	out_item_t   expected_q[$];

	assign pending = expected_q.size();

	function automatic int sx16(logic [15:0] v);
		return int'($signed(v));
	endfunction

	task automatic predict_item(input in_item_t it);
		logic [31:0] d, a;
		int          sp, cur, e, g, outv, drv;
		out_item_t   r;
		case (op_t'(it.operation))
			OP_INJ: begin
				if (!started && ended) begin
					period = it.timer_value;
					errs = 0;
				end else begin
					period = 0;
				end
				started = 1;
				ended = 0;
			end
			OP_CRANK: begin
				if (started && !ended) begin
					offset = it.timer_value;
					started = 0;
					ended = 1;
				end
				if (period > 100)
					speed = 16'((1250000 / period) * 12);
			end
			OP_OVF: begin
				if (errs < 20)
					errs = errs + 10;
			end
			default: begin
				if (period != 0) begin
					errs = 0;
					d = 32'(16'(period - offset));
					a = 32'(16'((d * 3600) / period));
					a = 32'(16'(a + 5)) / 10;
					if (a > 180) begin
						a = 32'(16'(360 - a));
						sgn = 1;
					end else begin
						sgn = 0;
					end
					asum = 16'(asum + a);
					nsamp++;
					if (nsamp >= AVG_LEN_DEF) begin
						aavg = asum / AVG_LEN_DEF;
						asum = 0;
						nsamp = 0;
					end
				end
				if (errs < 5) begin
					drv = drive;
					if (sgn) begin
						sp = speed / 800 + 8;
						cur = aavg[7] ? int'(aavg[7:0]) - 256 : int'(aavg[7:0]);
						e = sp - cur;
						integ = 16'(integ + e * int'(iscale));
						g = (e >= 0) ? int'(kp_pos) : int'(kp_neg);
						outv = g * e + int'(ki) * sx16(integ);
						drv = drv - outv;
					end
					if (drv < 0)
						drv = 0;
					if (drv > 2550)
						drv = 2550;
					drive = 16'(drv);
				end
			end
		endcase
		r.angle_shown = aavg;
		r.angle_negative = sgn;
		r.engine_speed = speed;
		r.duty = 8'(drive / 10);
		r.fault = errs > 2;
		expected_q.push_back(r);
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t x;
		if (!arst_n) begin
			kp_pos = GAIN_POS_RST;
			kp_neg = GAIN_NEG_RST;
			ki = GAIN_INT_RST;
			iscale = SCALE_RST;
			period = 0; offset = 0; speed = 0; asum = 0; aavg = 0;
			integ = 0; drive = 0; started = 0; ended = 0; sgn = 0;
			errs = 0; nsamp = 0;
			fail_count = 0;
			expected_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				case (cfg_idx_t'(cfg_index))
					CFG_GAIN_POS: kp_pos = cfg_data[7:0];
					CFG_GAIN_NEG: kp_neg = cfg_data[7:0];
					CFG_GAIN_INT: ki = cfg_data[7:0];
					default:      iscale = cfg_data;
				endcase
			if (out_valid && out_ready) begin
				if (expected_q.size() == 0) begin
					$error("result with nothing expected");
					fail_count++;
				end else begin
					x = expected_q.pop_front();
					if (x.angle_shown !== out_item.angle_shown) begin
						$error("angle_shown exp %0d got %0d", x.angle_shown,
							out_item.angle_shown);
						fail_count++;
					end
					if (x.angle_negative !== out_item.angle_negative) begin
						$error("angle_negative exp %0d got %0d", x.angle_negative,
							out_item.angle_negative);
						fail_count++;
					end
					if (x.engine_speed !== out_item.engine_speed) begin
						$error("engine_speed exp %0d got %0d", x.engine_speed,
							out_item.engine_speed);
						fail_count++;
					end
					if (x.duty !== out_item.duty) begin
						$error("duty exp %0d got %0d", x.duty, out_item.duty);
						fail_count++;
					end
					if (x.fault !== out_item.fault) begin
						$error("fault exp %0d got %0d", x.fault, out_item.fault);
						fail_count++;
					end
				end
			end
			if (in_valid && in_ready)
				predict_item(in_item);
		end
	end

endmodule

// ----- dv/testbench.sv -----
// testbench top: clock, reset, stimulus and verdict for the timing meter
`timescale 1ns / 1ps

module testbench;
	import itmr_pkg::*;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        in_valid = 0;
	logic        in_ready;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_ready = 0;
	out_item_t   out_item;
	logic        cfg_valid = 0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;
	int          fail_count;
	int          pending;

	// idling control for the sender and the receiver
	bit quiet = 0;        // long stretch with no idling at all
	bit sink_hold = 0;    // receiver holds off while items keep coming
	int hold_cycles = 0;

	always #5 clk = ~clk;

	injection_timing_meter_and_regulator_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	itmr_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
		.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending)
	);

	// receiver: random stalls, plus one long hold-off counted here
	always @(posedge clk) begin
		if (sink_hold && hold_cycles < 600) begin
			hold_cycles <= hold_cycles + 1;
			out_ready <= 0;
		end else begin
			out_ready <= quiet ? 1'b1 : ($urandom_range(99) >= 7);
		end
	end

	// offer one item, with a random idle gap first; valid stays up after it
	task automatic send_item(input op_t op, input logic [15:0] tv);
		in_item_t it;
		it.operation = op;
		it.timer_value = tv;
		if (!quiet && $urandom_range(99) < 7) begin
			in_valid <= 0;
			do
				@(posedge clk);
			while (!quiet && $urandom_range(99) < 7);
		end
		in_valid <= 1;
		in_item <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// stop offering and wait until every expected result is back
	task automatic drain();
		in_valid <= 0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// wait for the block to drain, then write a register while it idles
	task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
		drain();
		repeat (200) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 0;
	endtask

	// well-formed engine cycle: injector, crank, tick; crank and tick timer values random
	task automatic engine_cycle(input logic [15:0] per);
		send_item(OP_INJ, per);
		send_item(OP_CRANK, logic'($urandom_range(1)) ? 16'($urandom_range(per))
			: 16'($urandom));
		send_item(OP_TICK, 16'($urandom));
	endtask

	task automatic random_phase(input int n);
		int k;
		for (k = 0; k < n; k++) begin
			case ($urandom_range(9))
				0: send_item(op_t'($urandom_range(3)), 16'($urandom));
				1: send_item(OP_OVF, 16'($urandom));
				2: send_item(OP_TICK, 16'($urandom));
				3: send_item(OP_INJ, 16'($urandom_range(120)));
				default: begin
					engine_cycle($urandom_range(1) ? 16'($urandom)
						: 16'($urandom_range(4000, 200)));
					k += 2;
				end
			endcase
		end
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: field extremes, every operation, short and wrapped periods
		send_item(OP_TICK, 16'h0000);
		send_item(OP_OVF, 16'hffff);
		send_item(OP_OVF, 16'h0000);
		send_item(OP_OVF, 16'h1234);
		send_item(OP_TICK, 16'hffff);
		send_item(OP_INJ, 16'hffff);
		send_item(OP_CRANK, 16'h0000);
		send_item(OP_INJ, 16'hffff);
		send_item(OP_CRANK, 16'hffff);
		send_item(OP_TICK, 16'h0000);
		send_item(OP_INJ, 16'd100);       // period too short for speed
		send_item(OP_CRANK, 16'd50);
		send_item(OP_TICK, 16'h0000);
		send_item(OP_INJ, 16'd101);
		send_item(OP_CRANK, 16'd60000);   // offset past the period, angle wraps
		send_item(OP_TICK, 16'h0000);
		engine_cycle(16'd1000);
		engine_cycle(16'd1000);
		send_item(OP_INJ, 16'd0);
		send_item(OP_CRANK, 16'd0);

		// pause until all results are back
		drain();

		// reset-value gains, then extremes and mid settings
		random_phase(90);
		write_reg(CFG_GAIN_POS, 16'd255);
		write_reg(CFG_GAIN_NEG, 16'd255);
		write_reg(CFG_GAIN_INT, 16'd255);
		write_reg(CFG_SCALE, 16'hffff);
		random_phase(90);

		// receiver holds off while items keep flowing
		sink_hold = 1;
		random_phase(40);
		write_reg(CFG_GAIN_POS, 16'd0);
		write_reg(CFG_GAIN_NEG, 16'd0);
		write_reg(CFG_GAIN_INT, 16'd0);
		write_reg(CFG_SCALE, 16'd0);
		random_phase(80);
		write_reg(CFG_GAIN_POS, 16'($urandom_range(255)));
		write_reg(CFG_GAIN_NEG, 16'($urandom_range(255)));
		write_reg(CFG_GAIN_INT, 16'($urandom_range(3)));
		write_reg(CFG_SCALE, 16'($urandom));
		quiet = 1;
		random_phase(100);
		quiet = 0;
		write_reg(CFG_GAIN_INT, 16'd1);
		write_reg(CFG_SCALE, 16'd10000);
		random_phase(130);

		drain();
		repeat (300) @(posedge clk);
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

endmodule
